/* rtl/adp_pkg.sv */
// shared constants and codes of the aged defrag pacer
`default_nettype none
package adp_pkg;

  localparam int TIME_W              = 64;
  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int INITIAL_CHECK       = 100;
  localparam int MIN_ITEMS_BEFORE_PAUSE = 10;
  localparam int MAX_SIZE_RESET      = 3584;

  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_RELOCATE = 2'd1;
  localparam logic [1:0] ACT_AGED     = 2'd2;

  localparam logic MODE_VISIT = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  localparam logic [1:0] REG_AGE_LIMIT     = 2'd0;
  localparam logic [1:0] REG_SIZE_LIMIT    = 2'd1;
  localparam logic [1:0] REG_DEADLINE_TIME = 2'd2;
  localparam logic [1:0] REG_CLOCK_PERIOD  = 2'd3;

  typedef logic [TIME_W-1:0] time_t;

endpackage
`default_nettype wire

/* rtl/adp_div.sv */
// shared radix-2 restoring divider, one quotient bit per cycle
`default_nettype none
module adp_div
  import adp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire time_t dividend,
  input  wire time_t divisor,
  output logic       done,
  output time_t      quotient
);

  localparam int CNT_W = $clog2(TIME_W);

  logic              busy;
  logic [CNT_W-1:0]  count;
  time_t             rem;
  time_t             dvs;
  logic [TIME_W:0]   shifted;
  logic [TIME_W+1:0] diff;

  assign shifted = {rem, quotient[TIME_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (!diff[TIME_W+1]) begin
        rem      <= diff[TIME_W-1:0];
        quotient <= {quotient[TIME_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[TIME_W-1:0];
        quotient <= {quotient[TIME_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/aged_defrag_pacer.sv */
// results: a clear item or a visit with no rate estimate is decided in the evaluate state and
// registered once the output is free; checkpoint visits that need the rate estimate give their
// result after two 64-step passes through the shared radix-2 divider
// no item is taken while one is at work, and a result that waits on a busy output holds back
// the next item
// reset: counters and sample cleared, checkpoint 100, sampling armed, registers at reset values
`default_nettype none
module aged_defrag_pacer
  import adp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [31:0] value_length,
  input  wire logic [7:0]  value_age,
  input  wire logic [63:0] now_time,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       action,
  output logic [7:0]       new_age,
  output logic             keep_going,
  output logic [31:0]      visits_done,
  output logic [31:0]      relocations_done
);

  localparam int CW = COUNT_WIDTH;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_EVAL       = 3'd1;
  localparam logic [2:0] S_DIV1_START = 3'd2;
  localparam logic [2:0] S_DIV1_WAIT  = 3'd3;
  localparam logic [2:0] S_DIV2_START = 3'd4;
  localparam logic [2:0] S_DIV2_WAIT  = 3'd5;
  localparam logic [2:0] S_FIN        = 3'd6;

  logic [2:0]  state;

  logic [7:0]  age_limit;
  logic [15:0] size_limit;
  time_t       deadline_time;
  logic [19:0] clock_period;

  logic          arm_sample;
  logic [CW-1:0] next_checkpoint;
  time_t         last_sample_time;
  logic [CW-1:0] last_sample_visits;
  logic [CW-1:0] visit_counter;
  logic [CW-1:0] relocation_counter;

  logic        mode_r;
  logic [31:0] len_r;
  logic [7:0]  age_r;
  time_t       now_r;

  logic          out_free;
  time_t         period;
  logic [CW-1:0] vc_inc;
  logic [CW-1:0] rc_next;
  logic [CW-1:0] visit_delta;
  logic          in_range;
  logic [1:0]    act_c;
  logic [7:0]    age_c;
  logic [CW:0]   cp_init_sum;
  logic [CW-1:0] cp_init;
  logic [TIME_W:0]   pi_sum;
  time_t             per_item;
  logic [TIME_W:0]   cp_est_sum;
  logic [CW-1:0]     cp_est;
  logic              est_low;

  logic  div_start;
  time_t div_a;
  time_t div_b;
  logic  div_done;
  time_t div_q;

  logic          emit;
  logic [1:0]    emit_action;
  logic          emit_go;
  logic [CW-1:0] emit_vc;
  logic [CW-1:0] emit_rc;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign period   = (clock_period == '0) ? TIME_W'(1) : TIME_W'(clock_period);
  assign vc_inc   = (visit_counter == CNT_MAX) ? visit_counter : visit_counter + CW'(1);
  assign in_range = (len_r != '0) && (len_r <= 32'(size_limit));

  always_comb begin
    act_c   = ACT_NONE;
    age_c   = age_r;
    rc_next = relocation_counter;
    if (in_range) begin
      if (age_r >= age_limit) begin
        act_c   = ACT_RELOCATE;
        rc_next = (relocation_counter == CNT_MAX) ? relocation_counter
                                                  : relocation_counter + CW'(1);
      end else begin
        act_c = ACT_AGED;
        age_c = (age_r == 8'hff) ? age_r : age_r + 8'd1;
      end
    end
  end

  assign cp_init_sum = {1'b0, vc_inc} + (CW+1)'(INITIAL_CHECK);
  assign cp_init     = cp_init_sum[CW] ? CNT_MAX : cp_init_sum[CW-1:0];

  assign pi_sum   = {1'b0, div_q} + {1'b0, period};
  assign per_item = pi_sum[TIME_W] ? {TIME_W{1'b1}} : pi_sum[TIME_W-1:0];

  assign cp_est_sum = (TIME_W+1)'(visit_counter) + {2'b00, div_q[TIME_W-1:1]};
  assign cp_est     = (cp_est_sum > (TIME_W+1)'(CNT_MAX)) ? CNT_MAX : cp_est_sum[CW-1:0];
  assign est_low    = div_q < TIME_W'(MIN_ITEMS_BEFORE_PAUSE);

  // visit delta wraps at the counter width
  assign visit_delta = visit_counter - last_sample_visits;

  always_comb begin
    div_start = 1'b0;
    div_a     = (now_r - last_sample_time) + period;
    div_b     = TIME_W'(visit_delta);
    if (state == S_DIV1_START) begin
      div_start = 1'b1;
    end else if (state == S_DIV2_START) begin
      div_start = 1'b1;
      div_a     = deadline_time - now_r;
      div_b     = per_item;
    end
  end

  adp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    emit        = 1'b0;
    emit_action = act_c;
    emit_go     = 1'b1;
    emit_vc     = vc_inc;
    emit_rc     = rc_next;
    if (state == S_EVAL && out_free) begin
      if (mode_r == MODE_CLEAR) begin
        emit        = 1'b1;
        emit_action = ACT_NONE;
        emit_vc     = '0;
        emit_rc     = '0;
      end else if (arm_sample || vc_inc < next_checkpoint
                   || vc_inc == last_sample_visits) begin
        emit = 1'b1;
      end else if (now_r >= deadline_time) begin
        emit    = 1'b1;
        emit_go = 1'b0;
      end
    end else if (state == S_FIN && out_free) begin
      emit    = 1'b1;
      emit_go = !est_low;
      emit_vc = visit_counter;
      emit_rc = relocation_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      age_limit          <= '0;
      size_limit         <= 16'(MAX_SIZE_RESET);
      deadline_time      <= {TIME_W{1'b1}};
      clock_period       <= 20'd1;
      arm_sample         <= 1'b1;
      next_checkpoint    <= CW'(INITIAL_CHECK);
      last_sample_time   <= '0;
      last_sample_visits <= '0;
      visit_counter      <= '0;
      relocation_counter <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_AGE_LIMIT:  age_limit  <= cfg_data[7:0];
          REG_SIZE_LIMIT: size_limit <= cfg_data[15:0];
          REG_DEADLINE_TIME: begin
            deadline_time <= cfg_data;
            arm_sample    <= 1'b1;
          end
          REG_CLOCK_PERIOD:   clock_period   <= cfg_data[19:0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            if (mode_r == MODE_CLEAR) begin
              visit_counter      <= '0;
              relocation_counter <= '0;
              state              <= S_IDLE;
            end else begin
              visit_counter      <= vc_inc;
              relocation_counter <= rc_next;
              if (arm_sample) begin
                arm_sample         <= 1'b0;
                next_checkpoint    <= cp_init;
                last_sample_time   <= now_r;
                last_sample_visits <= vc_inc;
              end
              state <= emit ? S_IDLE : S_DIV1_START;
            end
          end
        end
        S_DIV1_START: state <= S_DIV1_WAIT;
        S_DIV1_WAIT: begin
          if (div_done) begin
            state <= S_DIV2_START;
          end
        end
        S_DIV2_START: state <= S_DIV2_WAIT;
        S_DIV2_WAIT: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (!est_low) begin
              last_sample_time   <= now_r;
              last_sample_visits <= visit_counter;
              next_checkpoint    <= cp_est;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_r <= mode;
      len_r  <= value_length;
      age_r  <= value_age;
      now_r  <= now_time;
    end
    if (emit) begin
      action           <= emit_action;
      new_age          <= (emit_action == ACT_AGED) ? age_c : age_r;
      keep_going       <= emit_go;
      visits_done      <= 32'(emit_vc);
      relocations_done <= 32'(emit_rc);
    end
  end

endmodule
`default_nettype wire

/* sim/aged_defrag_pacer_test.sv */
// self-checking bench for aged_defrag_pacer: results checked against plan or predictor
module aged_defrag_pacer_test
  import adp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        mode;
    logic [31:0] value_length;
    logic [7:0]  value_age;
    logic [63:0] now_time;
  } visit_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  new_age;
    logic        keep_going;
    logic [31:0] visits;
    logic [31:0] relocations;
  } visit_result_t;

  typedef struct packed {
    logic          is_write;
    logic [1:0]    reg_idx;
    logic [63:0]   reg_data;
    visit_item_t   item;
    logic          typed;
    visit_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_AGE_LIMIT;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_VISIT;
  logic [31:0] value_length = '0;
  logic [7:0]  value_age = '0;
  logic [63:0] now_time = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  action;
  logic [7:0]  new_age;
  logic        keep_going;
  logic [31:0] visits_done;
  logic [31:0] relocations_done;

  aged_defrag_pacer uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .value_length(value_length), .value_age(value_age), .now_time(now_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .action(action), .new_age(new_age), .keep_going(keep_going),
    .visits_done(visits_done), .relocations_done(relocations_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and pacer state
  logic [7:0]  thr_r = 8'd0;
  logic [15:0] max_size_r = 16'(MAX_SIZE_RESET);
  logic [63:0] deadline_r = '1;
  logic [19:0] period_r = 20'd1;
  logic        arm_r = 1'b1;
  logic [31:0] checkpoint_r = 32'(INITIAL_CHECK);
  logic [63:0] sample_time_r = '0;
  logic [31:0] sample_visits_r = '0;
  logic [31:0] visit_cnt_r = '0;
  logic [31:0] reloc_cnt_r = '0;

  visit_result_t expected_q[$];
  plan_row_t     plan_q[$];
  int unsigned   failures = 0;
  int unsigned   items_sent = 0;
  int unsigned   clears_sent = 0;
  int unsigned   rate_checks = 0;
  int unsigned   pauses = 0;
  int unsigned   reg_writes = 0;
  bit            send_steady = 1'b0;

  function automatic logic [31:0] sat_count(input logic [31:0] a, input logic [63:0] b);
    logic [63:0] room;
    room = {32'd0, 32'hFFFF_FFFF - a};
    return (b >= room) ? 32'hFFFF_FFFF : a + b[31:0];
  endfunction

  function automatic bit pace_check(input logic [63:0] now);
    logic [63:0] period, tdelta, vdelta, quot, per_item, est;
    logic [31:0] vdiff;
    period = (period_r == '0) ? 64'd1 : {44'd0, period_r};
    if (arm_r) begin
      checkpoint_r = sat_count(visit_cnt_r, 64'(INITIAL_CHECK));
      sample_time_r = now;
      sample_visits_r = visit_cnt_r;
      arm_r = 1'b0;
    end
    if (visit_cnt_r < checkpoint_r || visit_cnt_r == sample_visits_r) return 1'b1;
    rate_checks++;
    if (now >= deadline_r) return 1'b0;
    tdelta = now - sample_time_r + period;
    vdiff = visit_cnt_r - sample_visits_r;
    vdelta = {32'd0, vdiff};
    quot = tdelta / vdelta;
    per_item = (quot > ~64'd0 - period) ? ~64'd0 : quot + period;
    est = (deadline_r - now) / per_item;
    if (est < 64'(MIN_ITEMS_BEFORE_PAUSE)) return 1'b0;
    sample_time_r = now;
    sample_visits_r = visit_cnt_r;
    checkpoint_r = sat_count(visit_cnt_r, est >> 1);
    return 1'b1;
  endfunction

  task automatic predict_item(input visit_item_t it, output visit_result_t res);
    res.action = ACT_NONE;
    res.new_age = it.value_age;
    res.keep_going = 1'b1;
    if (it.mode == MODE_CLEAR) begin
      visit_cnt_r = '0;
      reloc_cnt_r = '0;
      clears_sent++;
    end else begin
      if (it.value_length != 0 && it.value_length <= {16'd0, max_size_r}) begin
        if (it.value_age >= thr_r) begin
          res.action = ACT_RELOCATE;
          reloc_cnt_r = sat_count(reloc_cnt_r, 64'd1);
        end else begin
          res.action = ACT_AGED;
          res.new_age = (it.value_age == 8'hFF) ? 8'hFF : it.value_age + 8'd1;
        end
      end
      visit_cnt_r = sat_count(visit_cnt_r, 64'd1);
      res.keep_going = pace_check(it.now_time);
      if (!res.keep_going) pauses++;
    end
    res.visits = visit_cnt_r;
    res.relocations = reloc_cnt_r;
  endtask

  function automatic void plan_write(input logic [1:0] idx, input logic [63:0] data);
    plan_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.reg_data = data;
    plan_q.push_back(r);
  endfunction

  function automatic void plan_visit(input visit_item_t it, input bit typed,
                                     input visit_result_t want);
    plan_row_t r;
    r = '0;
    r.item = it;
    r.typed = typed;
    r.want = want;
    plan_q.push_back(r);
  endfunction

  // called only while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_AGE_LIMIT:  thr_r = data[7:0];
      REG_SIZE_LIMIT: max_size_r = data[15:0];
      REG_DEADLINE_TIME: begin
        deadline_r = data;
        arm_r = 1'b1;
      end
      REG_CLOCK_PERIOD:   period_r = data[19:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic offer_item(input visit_item_t it, input bit typed, input visit_result_t want);
    int unsigned gap;
    visit_result_t predicted;
    if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
    gap = send_steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= it.mode;
    value_length <= it.value_length;
    value_age <= it.value_age;
    now_time <= it.now_time;
    do @(posedge clk); while (!in_ready);
    predict_item(it, predicted);
    expected_q.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  always @(posedge clk) begin
    visit_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no item waiting: visits_done %0d", visits_done);
        failures++;
      end else begin
        want = expected_q.pop_front();
        if (action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, action);
          failures++;
        end
        if (new_age !== want.new_age) begin
          $error("new_age: expected %0d, got %0d", want.new_age, new_age);
          failures++;
        end
        if (keep_going !== want.keep_going) begin
          $error("keep_going: expected %0d, got %0d", want.keep_going, keep_going);
          failures++;
        end
        if (visits_done !== want.visits) begin
          $error("visits_done: expected %0d, got %0d", want.visits, visits_done);
          failures++;
        end
        if (relocations_done !== want.relocations) begin
          $error("relocations_done: expected %0d, got %0d", want.relocations,
                 relocations_done);
          failures++;
        end
      end
    end
  end

  initial begin : result_sink
    int unsigned stall, taken;
    bit steady;
    taken = 0;
    steady = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == 250) begin
        stall = 600;
      end else begin
        if ($urandom_range(0, 31) == 0) steady = !steady;
        stall = steady ? 0 : $urandom_range(0, 16);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    visit_item_t it;
    logic [63:0] t, per_guess, data;
    int unsigned step_max, n, random_items;

    // directed: reset values first, then threshold, size and pacer registers
    plan_visit('{MODE_VISIT, 32'd0, 8'd0, 64'd0}, 1'b1,
               '{ACT_NONE, 8'd0, 1'b1, 32'd1, 32'd0});
    plan_visit('{MODE_VISIT, 32'd1, 8'd0, 64'd5}, 1'b1,
               '{ACT_RELOCATE, 8'd0, 1'b1, 32'd2, 32'd1});
    plan_visit('{MODE_VISIT, 32'd3584, 8'd255, 64'd10}, 1'b1,
               '{ACT_RELOCATE, 8'd255, 1'b1, 32'd3, 32'd2});
    plan_visit('{MODE_VISIT, 32'd3585, 8'd7, 64'd15}, 1'b1,
               '{ACT_NONE, 8'd7, 1'b1, 32'd4, 32'd2});
    plan_visit('{MODE_VISIT, 32'hFFFF_FFFF, 8'h80, 64'd20}, 1'b1,
               '{ACT_NONE, 8'h80, 1'b1, 32'd5, 32'd2});
    plan_visit('{MODE_CLEAR, 32'h1234_5678, 8'h5A, ~64'd0}, 1'b1,
               '{ACT_NONE, 8'h5A, 1'b1, 32'd0, 32'd0});
    plan_write(REG_AGE_LIMIT, 64'd200);
    plan_visit('{MODE_VISIT, 32'd10, 8'd199, 64'd25}, 1'b1,
               '{ACT_AGED, 8'd200, 1'b1, 32'd1, 32'd0});
    plan_visit('{MODE_VISIT, 32'd10, 8'd255, 64'd30}, 1'b1,
               '{ACT_RELOCATE, 8'd255, 1'b1, 32'd2, 32'd1});
    plan_write(REG_AGE_LIMIT, 64'd255);
    plan_visit('{MODE_VISIT, 32'd3584, 8'd254, 64'd35}, 1'b1,
               '{ACT_AGED, 8'd255, 1'b1, 32'd3, 32'd1});
    plan_visit('{MODE_VISIT, 32'd1, 8'd0, 64'd40}, 1'b1,
               '{ACT_AGED, 8'd1, 1'b1, 32'd4, 32'd1});
    plan_write(REG_SIZE_LIMIT, 64'd0);
    plan_visit('{MODE_VISIT, 32'd1, 8'd3, 64'd45}, 1'b1,
               '{ACT_NONE, 8'd3, 1'b1, 32'd5, 32'd1});
    plan_write(REG_SIZE_LIMIT, 64'hFFFF);
    plan_visit('{MODE_VISIT, 32'd65535, 8'd255, 64'd50}, 1'b1,
               '{ACT_RELOCATE, 8'd255, 1'b1, 32'd6, 32'd2});
    plan_visit('{MODE_VISIT, 32'd65536, 8'd9, 64'd55}, 1'b1,
               '{ACT_NONE, 8'd9, 1'b1, 32'd7, 32'd2});
    plan_write(REG_CLOCK_PERIOD, 64'd0);
    plan_write(REG_DEADLINE_TIME, 64'd50);
    plan_visit('{MODE_VISIT, 32'd0, 8'd0, ~64'd0}, 1'b0, '0);
    plan_write(REG_DEADLINE_TIME, ~64'd0);
    plan_write(REG_CLOCK_PERIOD, 64'd1000000);
    plan_visit('{MODE_VISIT, 32'd100, 8'd255, 64'd0}, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_write) begin
        drain_block();
        write_reg(plan_q[i].reg_idx, plan_q[i].reg_data);
      end else begin
        offer_item(plan_q[i].item, plan_q[i].typed, plan_q[i].want);
      end
    end

    // random phases: new settings, then a run of visits with a moving clock
    t = 64'd1000;
    random_items = 0;
    while (random_items < 1800) begin
      drain_block();
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 3))
          0: data = 64'd0;
          1: data = 64'hFF;
          default: data = {$urandom, $urandom};
        endcase
        write_reg(REG_AGE_LIMIT, data);
      end
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: data = 64'd0;
          1: data = 64'hFFFF;
          2: data = 64'(MAX_SIZE_RESET);
          3: data = 64'($urandom_range(1, 64));
          default: data = {$urandom, $urandom};
        endcase
        write_reg(REG_SIZE_LIMIT, data);
      end
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0: data = 64'd0;
          1: data = 64'd1;
          2: data = 64'd1000000;
          3: data = 64'hF_FFFF;
          4: data = 64'($urandom_range(1, 50));
          default: data = {$urandom, $urandom};
        endcase
        write_reg(REG_CLOCK_PERIOD, data);
      end
      case ($urandom_range(0, 4))
        0: step_max = 0;
        1: step_max = 1;
        2: step_max = 20;
        3: step_max = 3000;
        default: step_max = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0: t = {$urandom, $urandom};
        1: t = ~64'd0 - 64'($urandom_range(0, 100000));
        default: ;
      endcase
      if ($urandom_range(0, 4) != 0) begin
        per_guess = 64'(step_max / 2) + ((period_r == '0) ? 64'd1 : {44'd0, period_r});
        case ($urandom_range(0, 7))
          0: data = ~64'd0;
          1: data = 64'd0;
          2: data = t;
          3: data = {$urandom, $urandom};
          default: data = t + per_guess * 64'($urandom_range(60, 400));
        endcase
        write_reg(REG_DEADLINE_TIME, data);
      end
      n = $urandom_range(40, 260);
      repeat (n) begin
        it.mode = ($urandom_range(0, 79) == 0) ? MODE_CLEAR : MODE_VISIT;
        case ($urandom_range(0, 6))
          0: it.value_length = 32'd0;
          1: it.value_length = (max_size_r == '0) ? 32'd1 :
                               $urandom_range(1, {16'd0, max_size_r});
          2: it.value_length = {16'd0, max_size_r};
          3: it.value_length = {16'd0, max_size_r} + 32'd1;
          4: it.value_length = $urandom_range(1, 4096);
          5: it.value_length = 32'hFFFF_FFFF;
          default: it.value_length = $urandom;
        endcase
        case ($urandom_range(0, 5))
          0: it.value_age = thr_r;
          1: it.value_age = thr_r - 8'd1;
          2: it.value_age = 8'hFF;
          3: it.value_age = 8'd0;
          default: it.value_age = 8'($urandom);
        endcase
        t = t + 64'($urandom_range(0, step_max));
        case ($urandom_range(0, 59))
          0: it.now_time = {$urandom, $urandom};
          1: it.now_time = t - 64'($urandom);
          default: it.now_time = t;
        endcase
        offer_item(it, 1'b0, '0);
        random_items++;
      end
    end

    drain_block();
    repeat (200) @(posedge clk);
    $display("summary: %0d items (%0d clears), %0d rate checks, %0d pauses, %0d reg writes",
             items_sent, clears_sent, rate_checks, pauses, reg_writes);
    if (failures == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
rtl/adp_pkg.sv
rtl/adp_div.sv
rtl/aged_defrag_pacer.sv
sim/aged_defrag_pacer_test.sv
